// ===== hw/rtl/hdlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Shared types, constants and the FCS-16 byte update for the HDLC deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hdlcd_pkg;

    localparam logic [7:0]  FLAG_BYTE     = 8'h7e;
    localparam logic [15:0] FCS_INIT      = 16'hffff;
    localparam logic [15:0] FCS_GOOD      = 16'hf0b8;
    localparam logic [15:0] FCS_POLY_REFL = 16'h8408;
    localparam logic [2:0]  STUFF_RUN     = 3'd5;
    localparam logic [2:0]  ONES_MAX      = 3'd7;
    localparam logic [7:0]  MIN_LEN_RESET = 8'd13;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_OPEN  = 2'd1,
        PH_FRAME = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_FCS_ERR = 2'd2,
        ST_SHORT   = 2'd3
    } t_status;

    // bit-level unstuffing state
    typedef struct packed {
        logic [7:0] asm_byte;
        logic [2:0] bit_pos;
        logic [2:0] ones_run;
    } t_bit_state;

    // frame-level state
    typedef struct packed {
        t_phase      phase;
        logic [15:0] fcs;
        logic [7:0]  byte_count;
    } t_frame_state;

    // completed byte from the unstuffer
    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } t_byte_evt;

    typedef struct packed {
        logic       valid;
        logic [7:0] frame_byte;
        logic       frame_end;
        t_status    status;
    } t_result;

    // reflected CRC-16 (X.25), one byte LSB first
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] c;
        c = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hdlcd_unstuff.sv =====
// ----------------------------------------------------------------------------
// hdlcd_unstuff
// Drops stuffed zeros from one received byte and assembles kept bits, LSB
// first. At most one byte can complete per input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlcd_unstuff
    import hdlcd_pkg::*;
(
    input  wire logic [7:0] i_data,
    input  wire t_bit_state i_state,
    output t_bit_state      o_state,
    output t_byte_evt       o_evt
);

    always_comb begin
        logic [7:0] v_asm;
        logic [2:0] v_pos;
        logic [2:0] v_ones;
        logic       v_keep;
        logic       v_done;
        logic [7:0] v_byte;
        v_asm  = i_state.asm_byte;
        v_pos  = i_state.bit_pos;
        v_ones = i_state.ones_run;
        v_done = 1'b0;
        v_byte = 8'h00;
        for (int n = 0; n < 8; n++) begin
            v_keep = 1'b1;
            if (i_data[n]) begin
                v_asm[v_pos] = 1'b1;
                if (v_ones != ONES_MAX) begin
                    v_ones = v_ones + 3'd1;
                end
            end else if (v_ones == STUFF_RUN) begin
                // stuffed zero after five ones
                v_ones = 3'd0;
                v_keep = 1'b0;
            end else begin
                v_ones = 3'd0;
            end
            if (v_keep) begin
                v_pos = v_pos + 3'd1;
                if (v_pos == 3'd0) begin
                    v_done = 1'b1;
                    v_byte = v_asm;
                    v_asm  = 8'h00;
                end
            end
        end
        o_state.asm_byte = v_asm;
        o_state.bit_pos  = v_pos;
        o_state.ones_run = v_ones;
        o_evt.done       = v_done;
        o_evt.data       = v_byte;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hdlcd_framer.sv =====
// ----------------------------------------------------------------------------
// hdlcd_framer
// Flag detection, frame phase tracking, byte count and FCS check for one
// completed byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlcd_framer
    import hdlcd_pkg::*;
(
    input  wire t_byte_evt    i_evt,
    input  wire t_frame_state i_state,
    input  wire logic [7:0]   i_min_len,
    output t_frame_state      o_state,
    output t_result           o_result
);

    logic       w_flag;
    logic       w_short;
    logic [8:0] w_len;

    assign w_flag  = (i_evt.data == FLAG_BYTE);
    assign w_len   = {1'b0, i_state.byte_count} + 9'd2;
    assign w_short = (w_len < {1'b0, i_min_len});

    // next state
    always_comb begin
        o_state = i_state;
        if (i_evt.done) begin
            case (i_state.phase)
                PH_OPEN, PH_FRAME: begin
                    if (w_flag) begin
                        if (i_state.phase == PH_FRAME) begin
                            // closing flag opens the next frame
                            o_state.phase      = PH_OPEN;
                            o_state.fcs        = FCS_INIT;
                            o_state.byte_count = 8'd0;
                        end
                    end else begin
                        o_state.phase = PH_FRAME;
                        o_state.fcs   = fcs_update(i_state.fcs, i_evt.data);
                        if (i_state.byte_count != COUNT_MAX) begin
                            o_state.byte_count = i_state.byte_count + 8'd1;
                        end
                    end
                end
                default: begin
                    if (w_flag) begin
                        o_state.phase      = PH_OPEN;
                        o_state.fcs        = FCS_INIT;
                        o_state.byte_count = 8'd0;
                    end else begin
                        o_state.phase = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_result.valid      = 1'b0;
        o_result.frame_byte = i_evt.data;
        o_result.frame_end  = 1'b0;
        o_result.status     = ST_BYTE;
        if (i_evt.done) begin
            case (i_state.phase)
                PH_FRAME: begin
                    o_result.valid = 1'b1;
                    if (w_flag) begin
                        o_result.frame_end = 1'b1;
                        if (w_short) begin
                            o_result.status = ST_SHORT;
                        end else if (i_state.fcs != FCS_GOOD) begin
                            o_result.status = ST_FCS_ERR;
                        end else begin
                            o_result.status = ST_GOOD;
                        end
                    end
                end
                PH_OPEN: begin
                    o_result.valid = !w_flag;
                end
                default: begin
                    o_result.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hdlc_deframe_fcs16_check_unit.sv =====
// ----------------------------------------------------------------------------
// hdlc_deframe_fcs16_check_unit
// HDLC bit unstuffer and deframer with FCS-16 check, one byte per cycle
// while the result side accepts; input and result words are both registered.
// Throughput: 1 input word per cycle while the result side accepts; bounded by
//   the combinational unstuff plus CRC update loop on the deframer state.
// Reset (synchronous, active low): deframer state cleared, hunting for flag,
//   min_frame_length back to 13, both pipeline registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_deframe_fcs16_check_unit
    import hdlcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration: min_frame_length
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    // input stream
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic       i_s_axis_tuser,   // [0] burst_start
    // result stream
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] frame_byte
    output logic            o_m_axis_tlast,   // frame_end
    output logic [1:0]      o_m_axis_tuser    // [1:0] status
);

    logic         r_in_valid;
    logic         n_in_valid;
    logic [7:0]   r_in_data;
    logic         r_in_burst;
    logic         r_out_valid;
    logic         n_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_end;
    t_status      r_out_status;
    logic [7:0]   r_min_len;
    t_bit_state   r_bit_st;
    t_frame_state r_frm_st;

    logic         w_can_proc;
    logic         w_proc;
    logic         w_in_take;
    t_bit_state   w_bit_start;
    t_bit_state   w_bit_next;
    t_frame_state w_frm_start;
    t_frame_state w_frm_next;
    t_byte_evt    w_evt;
    t_result      w_res;

    assign o_cfg_ready     = 1'b1;
    assign w_can_proc      = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_can_proc;
    assign o_s_axis_tready = !r_in_valid || w_can_proc;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // burst start clears deframer state ahead of this word
    always_comb begin
        if (r_in_burst) begin
            w_bit_start.asm_byte   = 8'h00;
            w_bit_start.bit_pos    = 3'd0;
            w_bit_start.ones_run   = 3'd0;
            w_frm_start.phase      = PH_HUNT;
            w_frm_start.fcs        = FCS_INIT;
            w_frm_start.byte_count = 8'd0;
        end else begin
            w_bit_start = r_bit_st;
            w_frm_start = r_frm_st;
        end
    end

    hdlcd_unstuff u_unstuff (
        .i_data  (r_in_data),
        .i_state (w_bit_start),
        .o_state (w_bit_next),
        .o_evt   (w_evt)
    );

    hdlcd_framer u_framer (
        .i_evt     (w_evt),
        .i_state   (w_frm_start),
        .i_min_len (r_min_len),
        .o_state   (w_frm_next),
        .o_result  (w_res)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_s_axis_tready) begin
            n_in_valid = i_s_axis_tvalid;
        end
        n_out_valid = r_out_valid;
        if (w_can_proc) begin
            n_out_valid = w_proc && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_min_len             <= MIN_LEN_RESET;
            r_bit_st.asm_byte     <= 8'h00;
            r_bit_st.bit_pos      <= 3'd0;
            r_bit_st.ones_run     <= 3'd0;
            r_frm_st.phase        <= PH_HUNT;
            r_frm_st.fcs          <= FCS_INIT;
            r_frm_st.byte_count   <= 8'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_min_len <= i_cfg_data;
            end
            if (w_proc) begin
                r_bit_st <= w_bit_next;
                r_frm_st <= w_frm_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data  <= i_s_axis_tdata;
            r_in_burst <= i_s_axis_tuser;
        end
        if (w_proc && w_res.valid) begin
            r_out_byte   <= w_res.frame_byte;
            r_out_end    <= w_res.frame_end;
            r_out_status <= w_res.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_end;
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== tb/hdlc_deframe_fcs16_check_unit_test.sv =====
// ----------------------------------------------------------------------------
// hdlc_deframe_fcs16_check_unit_test
// Self-checking bench for the HDLC deframer. A bit-level line encoder builds
// flagged, stuffed frames with good or broken FCS, plus noise, aborts, extra
// flags and burst cuts. It ships the line bits as bytes with random gaps. A
// scoreboard mirrors the unstuffer and frame logic for every accepted word and
// compares each result word against the oldest prediction. The result side
// stalls at random. min_frame_length is swept over several values, including
// both ends of its range.
// ----------------------------------------------------------------------------
`default_nettype none

module hdlc_deframe_fcs16_check_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 205;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        t_status    status;
    } t_frame_word;

    class hdlc_frame_scoreboard;
        logic [7:0]  min_len;
        logic [7:0]  shift_byte;
        logic [2:0]  bit_pos;
        logic [2:0]  ones_run;
        t_phase      phase;
        logic [15:0] fcs;
        logic [7:0]  byte_count;
        t_frame_word expected_words[$];
        int          errors;

        function new();
            min_len = MIN_LEN_RESET;
            errors  = 0;
            clear();
        endfunction

        function void clear();
            shift_byte = '0;
            bit_pos    = '0;
            ones_run   = '0;
            phase      = PH_HUNT;
            fcs        = FCS_INIT;
            byte_count = '0;
        endfunction

        // X.25 CRC, reflected, one bit at a time
        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ FCS_POLY_REFL;
                end
            end
            return c;
        endfunction

        function void close_byte(logic [7:0] b);
            t_frame_word w;
            if (phase == PH_OPEN || phase == PH_FRAME) begin
                if (b == FLAG_BYTE) begin
                    // back-to-back flags leave an opened frame alone
                    if (phase == PH_FRAME) begin
                        w.frame_byte = FLAG_BYTE;
                        w.frame_end  = 1'b1;
                        if ({1'b0, byte_count} + 9'd2 < {1'b0, min_len}) begin
                            w.status = ST_SHORT;
                        end else if (fcs != FCS_GOOD) begin
                            w.status = ST_FCS_ERR;
                        end else begin
                            w.status = ST_GOOD;
                        end
                        expected_words.push_back(w);
                        phase      = PH_OPEN;
                        fcs        = FCS_INIT;
                        byte_count = '0;
                    end
                end else begin
                    phase = PH_FRAME;
                    fcs   = crc_step(fcs, b);
                    if (byte_count != COUNT_MAX) begin
                        byte_count++;
                    end
                    w.frame_byte = b;
                    w.frame_end  = 1'b0;
                    w.status     = ST_BYTE;
                    expected_words.push_back(w);
                end
            end else if (b == FLAG_BYTE) begin
                phase      = PH_OPEN;
                fcs        = FCS_INIT;
                byte_count = '0;
            end else begin
                phase = PH_HUNT;
            end
        endfunction

        function void note_rx_byte(logic [7:0] d, logic burst);
            logic [7:0] done_byte;
            if (burst) begin
                clear();
            end
            for (int n = 0; n < 8; n++) begin
                if (d[n]) begin
                    shift_byte[bit_pos] = 1'b1;
                    if (ones_run != ONES_MAX) begin
                        ones_run++;
                    end
                end else begin
                    // stuffed zero after exactly five ones is dropped
                    if (ones_run == STUFF_RUN) begin
                        ones_run = '0;
                        continue;
                    end
                    ones_run = '0;
                end
                bit_pos++;
                if (bit_pos == 3'd0) begin
                    done_byte  = shift_byte;
                    shift_byte = '0;
                    close_byte(done_byte);
                end
            end
        endfunction

        function void check_frame_word(logic [7:0] d, logic last, logic [1:0] st);
            t_frame_word w;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, actual byte %02h last %0b status %0d",
                         $time, d, last, st);
                return;
            end
            w = expected_words.pop_front();
            if (d !== w.frame_byte) begin
                errors++;
                $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                         $time, w.frame_byte, d);
            end
            if (last !== w.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                         $time, w.frame_end, last);
            end
            if (st !== w.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, w.status, st);
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       s_tvalid  = 1'b0;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       m_tready  = 1'b0;
    logic       cfg_ready;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    hdlc_frame_scoreboard sb;
    int   tx_idle_pct   = 25;
    int   rx_idle_pct   = 25;
    int   words_sent    = 0;
    int   cycle_count   = 0;
    bit   line_bits[$];
    logic burst_pending = 1'b0;
    int   tx_ones       = 0;

    hdlc_deframe_fcs16_check_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls, check every accepted word
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_frame_word(m_tdata, m_tlast, m_tuser);
        end
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_word(input logic [7:0] d, input logic burst);
        // one idle cycle at a time keeps the idle share near tx_idle_pct
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= burst;
        do @(posedge clk); while (!s_tready);
        sb.note_rx_byte(d, burst);
        words_sent++;
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        // a word that yields nothing may still be in the pipe
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_len(input logic [7:0] v);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        sb.min_len = v;
    endtask

    function automatic void put_raw(input logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            line_bits.push_back(b[i]);
        end
        tx_ones = 0;
    endfunction

    function automatic void put_stuffed(input logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            line_bits.push_back(b[i]);
            if (b[i]) begin
                tx_ones++;
                if (tx_ones == 5) begin
                    line_bits.push_back(1'b0);
                    tx_ones = 0;
                end
            end else begin
                tx_ones = 0;
            end
        end
    endfunction

    // payload + FCS, stuffed, then closing flag (which also opens the next frame)
    function automatic void put_frame(input int len, input logic corrupt);
        logic [7:0]  body[$];
        logic [7:0]  v;
        logic [15:0] crc;
        int          k;
        crc = FCS_INIT;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0: v = 8'hff;
                1: v = FLAG_BYTE;
                2: v = 8'h00;
                3: v = 8'h3e;
                default: v = 8'($urandom_range(0, 255));
            endcase
            body.push_back(v);
            crc = hdlc_frame_scoreboard::crc_step(crc, v);
        end
        crc = ~crc;
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (corrupt) begin
            k = $urandom_range(0, body.size() - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        tx_ones = 0;
        foreach (body[i]) begin
            put_stuffed(body[i]);
        end
        put_raw(FLAG_BYTE);
    endfunction

    task automatic ship_bits();
        logic [7:0] b;
        while (line_bits.size() >= 8) begin
            for (int i = 0; i < 8; i++) begin
                b[i] = line_bits.pop_front();
            end
            send_word(b, burst_pending);
            burst_pending = 1'b0;
        end
    endtask

    // drop whatever is on the line and restart, sometimes off byte alignment
    function automatic void cut_burst();
        line_bits.delete();
        burst_pending = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 7)) line_bits.push_back(1'($urandom_range(0, 1)));
        end
        put_raw(FLAG_BYTE);
    endfunction

    task automatic random_step();
        int r;
        int len;
        r   = $urandom_range(0, 99);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 14);
        if (r < 65) begin
            put_frame(len, 1'b0);
        end else if (r < 78) begin
            put_frame(len, 1'b1);
        end else if (r < 84) begin
            repeat ($urandom_range(1, 3)) put_raw(8'($urandom_range(0, 255)));
            put_raw(FLAG_BYTE);
        end else if (r < 89) begin
            // abort: eight ones in a row
            put_raw(8'hff);
            put_raw(FLAG_BYTE);
        end else if (r < 94) begin
            repeat ($urandom_range(1, 3)) put_raw(FLAG_BYTE);
        end else begin
            cut_burst();
        end
        ship_bits();
    endtask

    initial begin
        logic [7:0] setting;
        logic [7:0] settings[7];
        int         start;
        settings = '{8'd0, 8'd255, 8'd4, 8'd5, 8'd17, 8'd0, MIN_LEN_RESET};
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: hunting noise, burst open, repeated flag, short frame,
        // broken FCS at the reset length, burst cut inside a frame
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(FLAG_BYTE, 1'b1);
        send_word(FLAG_BYTE, 1'b0);
        put_frame(1, 1'b0);
        put_frame(9, 1'b1);
        put_stuffed(8'h12);
        put_stuffed(8'h34);
        ship_bits();
        cut_burst();
        ship_bits();

        for (int ph = 0; ph < 7; ph++) begin
            setting = (ph == 5) ? 8'($urandom_range(3, 30)) : settings[ph];
            write_min_len(setting);
            tx_idle_pct = (ph == 3) ? 0 : 25;
            rx_idle_pct = (ph == 3) ? 0 : 25;
            start = words_sent;
            if (setting == 8'd255) begin
                // byte count saturation, then a frame just under the limit
                put_frame(260, 1'b0);
                put_frame(250, 1'b0);
                ship_bits();
            end
            while (words_sent - start < PHASE_WORDS) begin
                random_step();
            end
        end

        pause_until_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/hdlcd_pkg.sv
hw/rtl/hdlcd_unstuff.sv
hw/rtl/hdlcd_framer.sv
hw/rtl/hdlc_deframe_fcs16_check_unit.sv
tb/hdlc_deframe_fcs16_check_unit_test.sv
